// File: hdl/rcls_pkg.sv
// rcls_pkg: shared types and constants of the rho collision log solver
// holds the beat structs, status codes, sequencer states and unit opcodes
// no dependencies
package rcls_pkg;

  localparam int WORD_BITS = 64;
  localparam int DATA_W    = WORD_BITS - 1;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EQUAL = 2'd1,
    ST_NOINV = 2'd2
  } status_e;

  typedef struct packed {
    logic [DATA_W-1:0] coef_c_first;
    logic [DATA_W-1:0] coef_c_second;
    logic [DATA_W-1:0] coef_d_first;
    logic [DATA_W-1:0] coef_d_second;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] log_value;
    status_e           status;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CDIF,
    S_CDIF2,
    S_DDIF,
    S_DDIF2,
    S_ALIGN,
    S_DIV,
    S_DBL,
    S_ADD,
    S_FIX,
    S_EUC,
    S_TUPD,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    M_NUM,
    M_DEN,
    M_EUC,
    M_MUL
  } mode_e;

  typedef enum logic [1:0] {
    OP_CSUB,
    OP_MADD,
    OP_MSUB
  } op_e;

endpackage

// File: hdl/rho_collision_log_solver_unit.sv
// rho_collision_log_solver_unit: discrete log from a rho walk collision
// one shared add/compare unit under a sequencer; needs rcls_pkg
//
// A command beat (start high while busy is low) carries the coefficients c1, c2, d1, d2.
// The block returns (c1 - c2) * (d2 - d1)^-1 mod group_order as one result beat: it shows
// on res_o for exactly one cycle with result_valid_o high, and the receiver cannot stall it.
// Equal d coefficients answer in the cycle right after the command beat with status 1.
// Otherwise the item runs through two reductions by shift-subtract division (long only for
// a small order), the extended Euclid loop (per quotient step a test of r1, one compare per
// alignment bit, a divide step per quotient bit with the quotient bits feeding a shift-add
// multiply by t, and an update of t), and a final 63-bit shift-add modular multiply. The
// additions, subtractions and magnitude compares of every step go through the one shared
// add/compare unit. A new command is taken in the cycle the result is shown.
// group_order sits at APB byte addresses 0 to 7 (paddr[3] low); values below two act as two.
module rho_collision_log_solver_unit
  import rcls_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd_i,
  output logic               result_valid_o,
  output res_t               res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int UW = WORD_BITS;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [DATA_W-1:0] go_q;
  logic [DATA_W-1:0] n_q, n_d;
  logic [DATA_W-1:0] c1_q, c1_d, c2_q, c2_d, d1_q, d1_d, d2_q, d2_d;
  logic [DATA_W-1:0] r0_q, r0_d, r1_q, r1_d, r1s_q, r1s_d;
  logic [DATA_W-1:0] t0_q, t0_d, t1_q, t1_d, acc_q, acc_d, num_q, num_d;
  logic [DATA_W-1:0] log_q, log_d;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              qbit_q, qbit_d, neg_q, neg_d;

  op_e               op;
  logic [UW-1:0]     ua, ub, um, u_res;
  logic              u_ge;
  logic [UW:0]       first, second_sub;
  logic [UW-1:0]     second_add;

  logic              accept, d_equal, last_step, take_bit, cfg_wr;
  logic [DATA_W-1:0] n_eff, fix_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && !paddr[3];
  assign prdata  = paddr[3] ? '0 : {{(PDATA_W-DATA_W){1'b0}}, go_q};
  assign n_eff   = (go_q < DATA_W'(2)) ? DATA_W'(2) : go_q;
  assign accept  = start && !busy;
  assign d_equal = (cmd_i.coef_d_first == cmd_i.coef_d_second);
  assign last_step = (k_q == '0);
  assign take_bit  = (mode_q == M_MUL) ? t0_q[k_q] : qbit_q;
  assign fix_val   = neg_q ? u_res[DATA_W-1:0] : r0_q;

  // shared add/compare unit
  always_comb begin
    first      = (op == OP_MADD) ? ({1'b0, ua} + {1'b0, ub}) : ({1'b0, ua} - {1'b0, ub});
    second_sub = {1'b0, first[UW-1:0]} - {1'b0, um};
    second_add = first[UW-1:0] + um;
    unique case (op)
      OP_CSUB: begin
        u_ge  = !first[UW];
        u_res = u_ge ? first[UW-1:0] : ua;
      end
      OP_MADD: begin
        u_ge  = !second_sub[UW];
        u_res = u_ge ? second_sub[UW-1:0] : first[UW-1:0];
      end
      OP_MSUB: begin
        u_ge  = !first[UW];
        u_res = u_ge ? first[UW-1:0] : second_add;
      end
      default: begin
        u_ge  = 1'b0;
        u_res = ua;
      end
    endcase
  end

  // unit operand select
  always_comb begin
    op = OP_CSUB;
    ua = '0;
    ub = '0;
    um = {1'b0, n_q};
    unique case (state_q)
      S_CDIF: begin
        ua = {1'b0, c1_q};
        ub = {1'b0, c2_q};
      end
      S_CDIF2: begin
        ua = {1'b0, c2_q};
        ub = {1'b0, c1_q};
      end
      S_DDIF: begin
        ua = {1'b0, d2_q};
        ub = {1'b0, d1_q};
      end
      S_DDIF2: begin
        ua = {1'b0, d1_q};
        ub = {1'b0, d2_q};
      end
      S_ALIGN: begin
        ua = {1'b0, r0_q};
        ub = {r1s_q, 1'b0};
      end
      S_DIV: begin
        ua = {1'b0, r0_q};
        ub = {1'b0, r1s_q};
      end
      S_DBL: begin
        op = OP_MADD;
        ua = {1'b0, acc_q};
        ub = {1'b0, acc_q};
      end
      S_ADD: begin
        op = OP_MADD;
        ua = {1'b0, acc_q};
        ub = (mode_q == M_MUL) ? {1'b0, num_q} : {1'b0, t1_q};
      end
      S_FIX: begin
        op = OP_MSUB;
        ub = {1'b0, r0_q};
      end
      S_TUPD: begin
        op = OP_MSUB;
        ua = {1'b0, t0_q};
        ub = {1'b0, acc_q};
      end
      default: begin
        op = OP_CSUB;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE, S_DONE: begin
        if (accept) begin
          state_d = d_equal ? S_DONE : S_CDIF;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CDIF:  state_d = u_ge ? S_ALIGN : S_CDIF2;
      S_CDIF2: state_d = S_ALIGN;
      S_DDIF:  state_d = u_ge ? S_ALIGN : S_DDIF2;
      S_DDIF2: state_d = S_ALIGN;
      S_ALIGN: state_d = u_ge ? S_ALIGN : S_DIV;
      S_DIV: begin
        if (mode_q == M_EUC) begin
          state_d = S_DBL;
        end else begin
          state_d = last_step ? S_FIX : S_DIV;
        end
      end
      S_DBL, S_ADD: begin
        if (state_q == S_DBL && take_bit) begin
          state_d = S_ADD;
        end else if (last_step) begin
          state_d = (mode_q == M_MUL) ? S_DONE : S_TUPD;
        end else begin
          state_d = (mode_q == M_MUL) ? S_DBL : S_DIV;
        end
      end
      S_FIX: state_d = (mode_q == M_NUM) ? S_DDIF : S_EUC;
      S_EUC: begin
        if (r1_q != '0) begin
          state_d = S_ALIGN;
        end else begin
          state_d = (r0_q == DATA_W'(1)) ? S_DBL : S_DONE;
        end
      end
      S_TUPD: state_d = S_EUC;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    mode_d   = mode_q;
    n_d      = n_q;
    c1_d     = c1_q;
    c2_d     = c2_q;
    d1_d     = d1_q;
    d2_d     = d2_q;
    r0_d     = r0_q;
    r1_d     = r1_q;
    r1s_d    = r1s_q;
    t0_d     = t0_q;
    t1_d     = t1_q;
    acc_d    = acc_q;
    num_d    = num_q;
    k_d      = k_q;
    qbit_d   = qbit_q;
    neg_d    = neg_q;
    log_d    = log_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE, S_DONE: begin
        if (accept) begin
          c1_d   = cmd_i.coef_c_first;
          c2_d   = cmd_i.coef_c_second;
          d1_d   = cmd_i.coef_d_first;
          d2_d   = cmd_i.coef_d_second;
          n_d    = n_eff;
          mode_d = M_NUM;
          if (d_equal) begin
            log_d    = '0;
            status_d = ST_EQUAL;
          end
        end
      end
      S_CDIF, S_CDIF2, S_DDIF, S_DDIF2: begin
        if (u_ge) begin
          r0_d  = u_res[DATA_W-1:0];
          neg_d = (state_q == S_CDIF2) || (state_q == S_DDIF2);
          r1s_d = n_q;
          k_d   = '0;
        end
        if (state_q == S_DDIF || state_q == S_DDIF2) begin
          mode_d = M_DEN;
        end
      end
      S_ALIGN: begin
        if (u_ge) begin
          r1s_d = {r1s_q[DATA_W-2:0], 1'b0};
          k_d   = k_q + CNT_W'(1);
        end
      end
      S_DIV: begin
        r0_d   = u_res[DATA_W-1:0];
        qbit_d = u_ge;
        if (mode_q != M_EUC && !last_step) begin
          k_d   = k_q - CNT_W'(1);
          r1s_d = r1s_q >> 1;
        end
      end
      S_DBL, S_ADD: begin
        acc_d = u_res[DATA_W-1:0];
        if (!(state_q == S_DBL && take_bit)) begin
          if (!last_step) begin
            k_d   = k_q - CNT_W'(1);
            r1s_d = r1s_q >> 1;
          end else if (mode_q == M_MUL) begin
            log_d    = u_res[DATA_W-1:0];
            status_d = ST_OK;
          end
        end
      end
      S_FIX: begin
        if (mode_q == M_NUM) begin
          num_d = fix_val;
        end else begin
          r0_d = n_q;
          r1_d = fix_val;
          t0_d = '0;
          t1_d = DATA_W'(1);
        end
      end
      S_EUC: begin
        acc_d = '0;
        if (r1_q != '0) begin
          r1s_d  = r1_q;
          k_d    = '0;
          mode_d = M_EUC;
        end else if (r0_q == DATA_W'(1)) begin
          k_d    = CNT_W'(DATA_W - 1);
          mode_d = M_MUL;
        end else begin
          log_d    = '0;
          status_d = ST_NOINV;
        end
      end
      S_TUPD: begin
        t1_d = u_res[DATA_W-1:0];
        t0_d = t1_q;
        r0_d = r1_q;
        r1_d = r0_q;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy           = !(state_q == S_IDLE || state_q == S_DONE);
    result_valid_o = (state_q == S_DONE);
    res_o.log_value = log_q;
    res_o.status    = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_NUM;
      go_q    <= DATA_W'(2);
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      if (cfg_wr) begin
        go_q <= pwdata[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    c1_q     <= c1_d;
    c2_q     <= c2_d;
    d1_q     <= d1_d;
    d2_q     <= d2_d;
    r0_q     <= r0_d;
    r1_q     <= r1_d;
    r1s_q    <= r1s_d;
    t0_q     <= t0_d;
    t1_q     <= t1_d;
    acc_q    <= acc_d;
    num_q    <= num_d;
    k_q      <= k_d;
    qbit_q   <= qbit_d;
    neg_q    <= neg_d;
    log_q    <= log_d;
    status_q <= status_d;
  end

  a_equal_fast : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && d_equal |=> result_valid_o && (res_o.status == ST_EQUAL))
    else $error("equal d coefficients not answered in the next cycle");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (res_o.status != ST_OK) |-> (res_o.log_value == '0))
    else $error("failure beat carries a nonzero log value");

  a_ok_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (res_o.status == ST_OK) |-> (res_o.log_value < n_q))
    else $error("log value not reduced below the group order");

endmodule

// File: bench/rcls_checker.sv
`timescale 1ns / 1ps
// rcls_checker: works out the discrete log for every accepted command beat and compares
// it with the result beats of the solver, following group_order through apb writes
// needs rcls_pkg
module rcls_checker
  import rcls_pkg::*;
#(
  parameter logic [PADDR_W-1:0] ORDER_ADDR = '0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  cmd_t               cmd_i,
  input  logic               res_valid_i,
  input  res_t               res_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);

  typedef logic [DATA_W-1:0] word_t;

  word_t       order_q;
  res_t        expected_logs[$];
  int unsigned errors_q;

  assign errors_o = errors_q;

  function automatic word_t mod_sub(word_t a, word_t b, word_t n);
    return (a >= b) ? a - b : n - (b - a);
  endfunction

  // shift-add multiply, one spare bit keeps the doubled accumulator exact
  function automatic word_t mod_mul(word_t a, word_t b, word_t n);
    logic [DATA_W:0] acc;
    acc = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      acc = acc << 1;
      if (acc >= n) acc = acc - n;
      if (b[i]) begin
        acc = acc + a;
        if (acc >= n) acc = acc - n;
      end
    end
    return acc[DATA_W-1:0];
  endfunction

  function automatic bit mod_inv(word_t a, word_t n, output word_t inv);
    word_t r0, r1, r2, t0, t1, t2, q;
    r0 = n;
    r1 = a;
    t0 = '0;
    t1 = 63'd1;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = mod_sub(t0, mod_mul(q % n, t1, n), n);
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    inv = t0;
    return r0 == 63'd1;
  endfunction

  function automatic res_t solve_log(cmd_t c, word_t order);
    word_t n, num, den, inv;
    res_t  r;
    n = (order < 63'd2) ? 63'd2 : order;
    r.log_value = '0;
    if (c.coef_d_first == c.coef_d_second) begin
      r.status = ST_EQUAL;
      return r;
    end
    num = mod_sub(c.coef_c_first % n, c.coef_c_second % n, n);
    den = mod_sub(c.coef_d_second % n, c.coef_d_first % n, n);
    if (!mod_inv(den, n, inv)) begin
      r.status = ST_NOINV;
      return r;
    end
    r.log_value = mod_mul(num, inv, n);
    r.status    = ST_OK;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      order_q <= 63'd2;
      expected_logs.delete();
      errors_q  <= 0;
      pending_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (expected_logs.size() == 0) begin
          if (errors_q < 10) begin
            $display("%0t: result beat with nothing expected: log_value %0d status %0d",
                     $time, res_i.log_value, res_i.status);
          end
          errors_q <= errors_q + 1;
        end else begin
          want = expected_logs.pop_front();
          if (res_i.log_value !== want.log_value || res_i.status !== want.status) begin
            if (errors_q < 10) begin
              $display("%0t: expected log_value %0d status %0d, got log_value %0d status %0d",
                       $time, want.log_value, want.status, res_i.log_value, res_i.status);
            end
            errors_q <= errors_q + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_logs.push_back(solve_log(cmd_i, order_q));
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ORDER_ADDR) begin
        order_q <= pwdata_i[DATA_W-1:0];
      end
      pending_o <= expected_logs.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives coefficient beats and group_order writes into the rho collision log
// solver and gives the verdict; needs rcls_pkg, rcls_checker and the solver unit
module tb_top;
  import rcls_pkg::*;

  localparam logic [PADDR_W-1:0] ORDER_ADDR  = '0;
  localparam int unsigned        CYCLE_LIMIT = 12_000_000;
  localparam int                 PHASES      = 12;
  localparam int                 PHASE_ITEMS = 78;
  localparam logic [DATA_W-1:0]  ALL_ONES    = '1;
  localparam logic [DATA_W-1:0]  MERSENNE_61 = 63'h1FFF_FFFF_FFFF_FFFF;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  cmd_t               cmd_i   = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic               busy;
  logic               result_valid_o;
  res_t               res_o;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int unsigned        pending;
  int unsigned        errors;

  logic [DATA_W-1:0]  group_n  = 63'd2;
  int unsigned        idle_pct = 0;

  always #6 clk_i = ~clk_i;

  rho_collision_log_solver_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  rcls_checker #(
    .ORDER_ADDR (ORDER_ADDR)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .cmd_i       (cmd_i),
    .res_valid_i (result_valid_o),
    .res_i       (res_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  function automatic logic [DATA_W-1:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] rand_coef(logic [DATA_W-1:0] n);
    case ($urandom_range(0, 15))
      0: return '0;
      1: return ALL_ONES;
      2: return n - 1;
      3: return n;
      4, 5, 6, 7, 8, 9: return rand_word() % n;
      default: return rand_word();
    endcase
  endfunction

  function automatic cmd_t mk_cmd(logic [DATA_W-1:0] c1, logic [DATA_W-1:0] c2,
                                  logic [DATA_W-1:0] d1, logic [DATA_W-1:0] d2);
    cmd_t c;
    c.coef_c_first  = c1;
    c.coef_c_second = c2;
    c.coef_d_first  = d1;
    c.coef_d_second = d2;
    return c;
  endfunction

  function automatic cmd_t random_cmd(logic [DATA_W-1:0] n);
    cmd_t          c;
    logic [DATA_W:0] sum;
    c.coef_c_first  = rand_coef(n);
    c.coef_c_second = rand_coef(n);
    c.coef_d_first  = rand_coef(n);
    case ($urandom_range(0, 15))
      0, 1: c.coef_d_second = c.coef_d_first;
      // d values apart by the order: differ but equal after reduction
      2, 3: begin
        sum = {1'b0, c.coef_d_first} + {1'b0, n};
        c.coef_d_second = sum[DATA_W] ? c.coef_d_first - n : sum[DATA_W-1:0];
      end
      default: c.coef_d_second = rand_coef(n);
    endcase
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] phase_order(int p);
    case (p)
      0: return 63'd3;
      1: return 63'd251;
      2: return 63'd1000;
      3: return MERSENNE_61;
      4: return rand_word();
      5: return 63'd65521;
      6: return 63'h1_0000_0000;
      7: return ALL_ONES;
      8: return 63'd9223372036854775783;
      9: return DATA_W'($urandom_range(2, 200));
      10: return 63'd2;
      default: return rand_word() | 63'd1;
    endcase
  endfunction

  task automatic write_order(input logic [DATA_W-1:0] val);
    logic hi_bit;
    hi_bit = 1'($urandom_range(0, 1));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ORDER_ADDR;
    pwdata  <= {hi_bit, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    group_n = (val < 63'd2) ? 63'd2 : val;
  endtask

  // returns at the edge that takes the beat; start stays high for a following beat
  task automatic drive_cmd(input cmd_t c);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1600) : $urandom_range(1, 8);
    end
    if (gap != 0) begin
      start <= 1'b0;
      cmd_i <= random_cmd(group_n);
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic close_phase();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("rho_collision_log_solver_unit test failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // order of two out of reset
    drive_cmd(mk_cmd(0, 0, 0, 1));
    drive_cmd(mk_cmd(1, 0, 0, 1));
    drive_cmd(mk_cmd(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    drive_cmd(mk_cmd(ALL_ONES, 0, 0, ALL_ONES));
    close_phase();

    // orders below two act as two
    write_order(0);
    drive_cmd(mk_cmd(1, 0, 1, 0));
    drive_cmd(mk_cmd(5, 3, 2, 4));
    close_phase();
    write_order(1);
    drive_cmd(mk_cmd(3, 0, 0, 3));
    close_phase();

    // large prime order, coefficients above it and d equal after reduction
    write_order(MERSENNE_61);
    drive_cmd(mk_cmd(0, ALL_ONES, 0, ALL_ONES));
    drive_cmd(mk_cmd(ALL_ONES, 0, ALL_ONES, 0));
    drive_cmd(mk_cmd(MERSENNE_61, MERSENNE_61 - 1, 1, MERSENNE_61 + 1));
    drive_cmd(mk_cmd(MERSENNE_61 - 1, 0, MERSENNE_61 - 1, 1));
    drive_cmd(mk_cmd(0, 0, 5, 5));
    drive_cmd(mk_cmd(123456789, 987654321, 42, 4242));
    drive_cmd(mk_cmd(0, 1, 0, 1));
    drive_cmd(mk_cmd(ALL_ONES, ALL_ONES - 1, MERSENNE_61 - 1, MERSENNE_61 - 2));
    close_phase();

    // composite order, divisor sharing a factor
    write_order(12);
    drive_cmd(mk_cmd(7, 1, 2, 4));
    drive_cmd(mk_cmd(7, 1, 1, 6));
    drive_cmd(mk_cmd(11, 0, 0, 12));
    drive_cmd(mk_cmd(0, 11, 11, 0));
    close_phase();

    for (int p = 0; p < PHASES; p++) begin
      write_order(phase_order(p));
      idle_pct = (p < 4) ? 30 : (p < 8) ? 51 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        drive_cmd(random_cmd(group_n));
      end
      close_phase();
    end

    repeat (64) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("rho_collision_log_solver_unit test passed");
    end else begin
      $display("rho_collision_log_solver_unit test failed");
    end
    $finish;
  end

endmodule
